### hdl/lpfm_pkg.sv
// Shared types and codes for the LRU page-frame manager.
// Used by lpfm_ctrl, lpfm_dpath and lru_page_frame_manager_top; no dependencies.
package lpfm_pkg;

  // Request operation codes
  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch a new item and clear the scan trackers
    logic scan;    // read the next frame and advance the counter
    logic update;  // commit state changes and issue the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // the counter points at the last frame
  } sts_t;

endpackage

### hdl/lpfm_ctrl.sv
// Controller state machine for the LRU page-frame manager.
// Depends on lpfm_pkg for the state enum and the command/status structs.
module lpfm_ctrl
  import lpfm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_SCAN:   cmd_o.scan = 1'b1;
      ST_DRAIN:  cmd_o = '0;
      ST_UPDATE: cmd_o.update = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

### hdl/lpfm_dpath.sv
// Datapath of the LRU page-frame manager: frame tag memory, valid/dirty/age
// flops, the serial scan trackers and the result registers. Uses lpfm_pkg.
module lpfm_dpath
  import lpfm_pkg::*;
#(
  parameter int NUM_FRAMES   = 16,
  parameter int PAGE_ID_BITS = 20,
  localparam int AW          = $clog2(NUM_FRAMES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic [1:0]              op_i,
  input  logic [PAGE_ID_BITS-1:0] page_id_i,
  output logic                    done_o,
  output logic                    hit_o,
  output logic [AW-1:0]           slot_o,
  output logic                    fetch_needed_o,
  output logic                    evicted_o,
  output logic [PAGE_ID_BITS-1:0] evicted_page_o,
  output logic                    write_back_o
);

  // Item registers
  logic [1:0]              op_q;
  logic [PAGE_ID_BITS-1:0] page_q;

  // Frame state
  logic [PAGE_ID_BITS-1:0] page_mem [NUM_FRAMES];
  logic                    valid_q  [NUM_FRAMES];
  logic                    dirty_q  [NUM_FRAMES];
  logic [AW-1:0]           age_q    [NUM_FRAMES];

  // Scan pipeline
  logic [AW-1:0]           cnt_q;
  logic [PAGE_ID_BITS-1:0] rd_q;
  logic [AW-1:0]           chk_idx_q;
  logic                    chk_en_q;

  // Scan trackers
  logic                    hit_found_q, inv_found_q, best_set_q;
  logic [AW-1:0]           hit_idx_q, inv_idx_q, best_idx_q, best_age_q;
  logic [PAGE_ID_BITS-1:0] best_page_q;

  // Update decode
  logic                    cur_valid;
  logic [AW-1:0]           cur_age;
  logic                    do_alloc, do_touch, do_dirty;
  logic [AW-1:0]           vic_idx, tgt_idx, tgt_age;

  assign sts_o.scan_last = (cnt_q == AW'(NUM_FRAMES - 1));

  assign cur_valid = valid_q[chk_idx_q];
  assign cur_age   = age_q[chk_idx_q];

  assign vic_idx  = inv_found_q ? inv_idx_q : best_idx_q;
  assign do_alloc = !hit_found_q && (op_q == OP_ACCESS || op_q == OP_STORE);
  assign do_touch = do_alloc || (hit_found_q && (op_q == OP_ACCESS || op_q == OP_STORE));
  assign do_dirty = hit_found_q && (op_q == OP_MARK || op_q == OP_STORE);
  assign tgt_idx  = hit_found_q ? hit_idx_q : vic_idx;
  assign tgt_age  = age_q[tgt_idx];

  // Step the counter, feed the compare stage and set the tracker flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      chk_en_q    <= 1'b0;
      chk_idx_q   <= '0;
      hit_found_q <= 1'b0;
      inv_found_q <= 1'b0;
      best_set_q  <= 1'b0;
    end else begin
      chk_en_q <= cmd_i.scan;
      if (cmd_i.scan) begin
        chk_idx_q <= cnt_q;
        if (!sts_o.scan_last) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        cnt_q       <= '0;
        hit_found_q <= 1'b0;
        inv_found_q <= 1'b0;
        best_set_q  <= 1'b0;
      end else if (chk_en_q) begin
        // Record the first match, the first free frame and the oldest frame
        if (cur_valid && rd_q == page_q && !hit_found_q) hit_found_q <= 1'b1;
        if (!cur_valid && !inv_found_q) inv_found_q <= 1'b1;
        if (cur_valid && (!best_set_q || cur_age > best_age_q)) best_set_q <= 1'b1;
      end
    end
  end

  // Item and tracker payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      page_q <= page_id_i;
    end
    if (chk_en_q && !cmd_i.load) begin
      if (cur_valid && rd_q == page_q && !hit_found_q) hit_idx_q <= chk_idx_q;
      if (!cur_valid && !inv_found_q) inv_idx_q <= chk_idx_q;
      if (cur_valid && (!best_set_q || cur_age > best_age_q)) begin
        best_idx_q  <= chk_idx_q;
        best_age_q  <= cur_age;
        best_page_q <= rd_q;
      end
    end
  end

  // Tag memory: one read a cycle during the scan, one write on allocation
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) rd_q <= page_mem[cnt_q];
    if (cmd_i.update && do_alloc) page_mem[vic_idx] <= page_q;
  end

  // Valid, dirty and recency flops, updated for all frames at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        valid_q[i] <= 1'b0;
        dirty_q[i] <= 1'b0;
        age_q[i]   <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (do_touch) begin
          if (AW'(i) == tgt_idx) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && (do_alloc || age_q[i] < tgt_age)) begin
            age_q[i] <= age_q[i] + 1'b1;
          end
        end
      end
      if (do_alloc) begin
        valid_q[vic_idx] <= 1'b1;
        dirty_q[vic_idx] <= (op_q == OP_STORE);
      end
      if (do_dirty) dirty_q[hit_idx_q] <= 1'b1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.update;
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o          <= hit_found_q;
      slot_o         <= hit_found_q ? hit_idx_q : (do_alloc ? vic_idx : '0);
      fetch_needed_o <= do_alloc && (op_q == OP_ACCESS);
      evicted_o      <= do_alloc && !inv_found_q;
      evicted_page_o <= (do_alloc && !inv_found_q) ? best_page_q : '0;
      write_back_o   <= do_alloc && !inv_found_q && dirty_q[best_idx_q];
    end
  end

endmodule

### hdl/lru_page_frame_manager_top.sv
// Top level of the LRU page-frame manager: controller plus datapath.
// Depends on lpfm_pkg, lpfm_ctrl and lpfm_dpath.
//
//  channel   signals                                    handshake
//  request   op_i, page_id_i                            start high while busy low
//  result    hit_o, slot_o, fetch_needed_o, evicted_o,  done_o high for one cycle
//            evicted_page_o, write_back_o
//
// After accept, an item goes through the scan, which reads one frame tag per cycle
// from the single-port tag memory, then a drain state that empties the compare
// stage and an update state that commits it. The result shows with done_o in the
// cycle after the commit, when start may already be taken again.
// Reset clears all frames to invalid, clean and most recent; the tag memory
// needs no clearing. The receiver cannot stall; busy holds off new requests.
module lru_page_frame_manager_top
  import lpfm_pkg::*;
#(
  parameter int NUM_FRAMES   = 16,
  parameter int PAGE_ID_BITS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op_i,
  input  logic [PAGE_ID_BITS-1:0]         page_id_i,
  output logic                            done_o,
  output logic                            hit_o,
  output logic [$clog2(NUM_FRAMES)-1:0]   slot_o,
  output logic                            fetch_needed_o,
  output logic                            evicted_o,
  output logic [PAGE_ID_BITS-1:0]         evicted_page_o,
  output logic                            write_back_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the scan and the update
  lpfm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Hold the frames and build the result
  lpfm_dpath #(
    .NUM_FRAMES   (NUM_FRAMES),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .page_id_i      (page_id_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .fetch_needed_o (fetch_needed_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .write_back_o   (write_back_o)
  );

endmodule

### tb/tb_lru_page_frame_manager_top.sv
// Testbench for lru_page_frame_manager_top: drives page requests and checks each result
// against a cycle-free LRU frame-table predictor. Depends on lpfm_pkg and the top module.
`timescale 1ns / 1ps

module tb_lru_page_frame_manager_top
  import lpfm_pkg::*;
;

  localparam int NUM_FRAMES   = 16;
  localparam int PAGE_ID_BITS = 20;
  localparam int SLOT_BITS    = $clog2(NUM_FRAMES);
  localparam int WATCHDOG_MAX = 4000;
  localparam int TAIL_CYCLES  = NUM_FRAMES + 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int WORKSET      = 22;

  typedef logic [PAGE_ID_BITS-1:0] page_t;

  // One page request waiting for the driver
  typedef struct {
    logic [1:0]  op;
    page_t       page;
    int unsigned idle_pct;
    bit          drain_first;
  } page_req_t;

  // Expected result of one request
  typedef struct {
    logic                 hit;
    logic [SLOT_BITS-1:0] slot;
    logic                 fetch;
    logic                 evicted;
    page_t                evicted_page;
    logic                 write_back;
  } frame_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic [1:0] op_i = OP_ACCESS;
  page_t page_id_i = '0;
  logic busy;
  logic done_o;
  logic hit_o;
  logic [SLOT_BITS-1:0] slot_o;
  logic fetch_needed_o;
  logic evicted_o;
  page_t evicted_page_o;
  logic write_back_o;

  page_req_t     pending_reqs[$];
  frame_result_t expected_results[$];

  // Predictor copy of the frame table
  bit    fr_valid[NUM_FRAMES];
  page_t fr_page[NUM_FRAMES];
  bit    fr_dirty[NUM_FRAMES];
  int    fr_rank[NUM_FRAMES];

  int n_driven     = 0;
  int n_accepted   = 0;
  int n_results    = 0;
  int mismatches   = 0;
  int n_hits       = 0;
  int n_fetches    = 0;
  int n_evictions  = 0;
  int n_writebacks = 0;
  int idle_cycles  = 0;

  lru_page_frame_manager_top #(
    .NUM_FRAMES  (NUM_FRAMES),
    .PAGE_ID_BITS(PAGE_ID_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .page_id_i     (page_id_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .slot_o        (slot_o),
    .fetch_needed_o(fetch_needed_o),
    .evicted_o     (evicted_o),
    .evicted_page_o(evicted_page_o),
    .write_back_o  (write_back_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Make frame s the most recent; a fresh frame ages every other valid frame
  function automatic void promote_frame(int s, bit fresh);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (i != s && fr_valid[i] && (fresh || fr_rank[i] < fr_rank[s])) begin
        fr_rank[i] = fr_rank[i] + 1;
      end
    end
    fr_rank[s] = 0;
  endfunction

  // Apply one request to the frame table and return its result
  function automatic frame_result_t lru_predict(logic [1:0] op, page_t pg);
    frame_result_t r;
    int found;
    int victim;
    r = '{default: '0};
    found = -1;
    victim = -1;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (found < 0 && fr_valid[i] && fr_page[i] == pg) found = i;
    end
    if (found >= 0) begin
      r.hit  = 1'b1;
      r.slot = SLOT_BITS'(found);
      case (op)
        OP_ACCESS: begin
          promote_frame(found, 1'b0);
        end
        OP_MARK: begin
          fr_dirty[found] = 1'b1;
        end
        OP_STORE: begin
          fr_dirty[found] = 1'b1;
          promote_frame(found, 1'b0);
        end
        default: begin
        end
      endcase
    end else if (op == OP_ACCESS || op == OP_STORE) begin
      // lowest free frame first, else the oldest (lowest index on a tie)
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (victim < 0 && !fr_valid[i]) victim = i;
      end
      if (victim < 0) begin
        victim = 0;
        for (int i = 1; i < NUM_FRAMES; i++) begin
          if (fr_rank[i] > fr_rank[victim]) victim = i;
        end
        r.evicted      = 1'b1;
        r.evicted_page = fr_page[victim];
        r.write_back   = fr_dirty[victim];
        fr_valid[victim] = 1'b0;
      end
      fr_page[victim]  = pg;
      fr_dirty[victim] = (op == OP_STORE);
      promote_frame(victim, 1'b1);
      fr_valid[victim] = 1'b1;
      r.slot  = SLOT_BITS'(victim);
      r.fetch = (op == OP_ACCESS);
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  task automatic add_req(input logic [1:0] op, input page_t pg,
                         input int unsigned idle_pct, input bit drain_first);
    page_req_t req;
    req.op          = op;
    req.page        = pg;
    req.idle_pct    = idle_pct;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  // Driver: hold an item until taken, then present the next one or idle
  always @(negedge clk_i) begin
    page_req_t req;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && n_accepted < n_driven) begin
      start <= 1'b1;
    end else if (pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (pending_reqs[0].drain_first && expected_results.size() != 0) begin
      start <= 1'b0;
    end else if ($urandom_range(99) < pending_reqs[0].idle_pct) begin
      start <= 1'b0;
    end else begin
      req = pending_reqs.pop_front();
      op_i      <= req.op;
      page_id_i <= req.page;
      start     <= 1'b1;
      n_driven++;
    end
  end

  // Monitor: check results, predict accepted items
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no item pending, expected none, actual slot %0h",
                   $time, slot_o);
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("slot", 32'(want.slot), 32'(slot_o));
          check_field("fetch_needed", 32'(want.fetch), 32'(fetch_needed_o));
          check_field("evicted", 32'(want.evicted), 32'(evicted_o));
          check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page_o));
          check_field("write_back", 32'(want.write_back), 32'(write_back_o));
          n_hits       += int'(want.hit);
          n_fetches    += int'(want.fetch);
          n_evictions  += int'(want.evicted);
          n_writebacks += int'(want.write_back);
        end
      end
      if (start && !busy) begin
        expected_results.push_back(lru_predict(op_i, page_id_i));
        n_accepted++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(start && !busy) && !done_o) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Stimulus and end of run
  initial begin
    page_t       workset[WORKSET];
    int unsigned idle_pct;
    int          counted;
    int          sel;
    logic [1:0]  op;
    page_t       pg;

    // directed: field extremes, every op, eviction order with dirty victims
    add_req(OP_ACCESS, '0, 34, 0);
    add_req(OP_ACCESS, '1, 34, 0);
    add_req(OP_ACCESS, '0, 34, 0);
    add_req(OP_MARK, '1, 34, 0);
    add_req(OP_MARK, 20'h12345, 34, 0);
    add_req(OP_STORE, 20'hAAAAA, 34, 0);
    add_req(OP_STORE, '0, 34, 0);
    add_req(OP_LOOKUP, '0, 34, 0);
    add_req(OP_LOOKUP, 20'h55555, 34, 0);
    for (int i = 0; i < 13; i++) add_req(OP_ACCESS, page_t'(20'h100 + i), 34, 0);
    for (int i = 0; i < 3; i++) add_req(OP_ACCESS, page_t'(20'h200 + i), 34, 0);

    // random: three idle phases, each with its own working set of pages
    counted = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 34 : (ph == 1) ? 62 : 0;
      for (int i = 0; i < WORKSET; i++) workset[i] = page_t'($urandom);
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        sel = $urandom_range(99);
        op  = (sel < 45) ? OP_ACCESS : (sel < 65) ? OP_MARK : (sel < 90) ? OP_STORE : OP_LOOKUP;
        sel = $urandom_range(99);
        if (sel < 45) pg = workset[$urandom_range(9)];
        else if (sel < 87) pg = workset[$urandom_range(WORKSET - 1)];
        else pg = page_t'($urandom);
        add_req(op, pg, idle_pct, (n == 0) || ($urandom_range(49) == 0));
        if (op != OP_LOOKUP) counted++;
      end
    end

    // hold reset, then release it on a falling edge
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // drain, then let the block settle
    while (pending_reqs.size() != 0 || n_accepted != n_driven || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests (%0d random ops that change state), %0d results checked.",
             n_accepted, counted, n_results);
    $display("Saw %0d hits, %0d fetches, %0d evictions, %0d write-backs.",
             n_hits, n_fetches, n_evictions, n_writebacks);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
